>>> rtl/multi_waveform_oscillator_defines.svh
// Assertion macros shared by the oscillator checkers.
`ifndef MULTI_WAVEFORM_OSCILLATOR_DEFINES_SVH
`define MULTI_WAVEFORM_OSCILLATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MWO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MWO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mwo_pkg.sv
`timescale 1ns / 1ps

package mwo_pkg;

    // Default build parameters
    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;

    // Port widths
    localparam int IN_DATA_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int WAVE_W     = 2;
    localparam int GAIN_W     = 16;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'h8000;
    // Unit amplitude, 1.0 in Q15, one bit wider than a table entry
    localparam logic [16:0] UNIT = 17'h08000;

    // Items in flight between the input and output handshakes
    localparam int PIPE_DEPTH = 3;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVE_SELECT = 2'd0,
        CFG_PHASE_STEP  = 2'd1,
        CFG_GAIN        = 2'd2
    } t_cfg_idx;

    typedef enum logic [WAVE_W-1:0] {
        WAVE_SINE = 2'd0,
        WAVE_SAW  = 2'd1,
        WAVE_RECT = 2'd2
    } t_wave;

    // Quarter sine entry k of 2^addr_bits, Q15, by Q30 Horner Taylor series.
    function automatic logic [15:0] quarter_sine(input int unsigned k,
                                                 input int unsigned addr_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] acc;
        logic [63:0] r;
        x   = (64'(k) * HALF_PI_Q30) >> addr_bits;
        x2  = (x * x) >> 30;
        acc = Q30_ONE - x2 / 64'd110;
        acc = Q30_ONE - ((x2 * acc) >> 30) / 64'd72;
        acc = Q30_ONE - ((x2 * acc) >> 30) / 64'd42;
        acc = Q30_ONE - ((x2 * acc) >> 30) / 64'd20;
        acc = Q30_ONE - ((x2 * acc) >> 30) / 64'd6;
        r   = (((x * acc) >> 30) + (64'd1 << 14)) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return r[15:0];
    endfunction

endpackage

>>> rtl/multi_waveform_oscillator.sv
// Phase-accumulator oscillator, one PCM sample per accepted transaction.
// An accepted transaction shows its sample after these registered stages in order
// (input stage with the registered sine ROM read, gain multiply, full-scale/saturate).
// Throughput: one transaction per cycle; a stall stops only the stages that are full.
// Reset (synchronous, active low): phase 0, first sample flagged as period start,
// sine waveform, zero phase step, gain 1.0; the sine ROM is constant, no fill pass.
`timescale 1ns / 1ps

module multi_waveform_oscillator #(
    parameter int PHASE_BITS      = mwo_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = mwo_pkg::TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = mwo_pkg::SAMPLE_BITS_DEF,
    localparam int OUT_W          = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [mwo_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mwo_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [mwo_pkg::IN_DATA_W-1:0]   i_s_tdata,   // [0] restart, rest zero
    // output stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [OUT_W-1:0]                o_m_tdata,   // [SAMPLE_BITS-1:0] pcm_sample
    output logic                            o_m_tuser    // [0] period_start
);

    localparam int TABLE_SIZE = 1 << TABLE_ADDR_BITS;
    localparam int MAG_W      = 17;
    localparam int PROD_W     = MAG_W + mwo_pkg::GAIN_W;
    localparam int SCL_W      = PROD_W + SAMPLE_BITS - 1;
    localparam int V_W        = SCL_W - 30;
    localparam logic [V_W-1:0] FULL_V = V_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic [V_W-1:0] NEG_LIM = FULL_V + V_W'(1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [mwo_pkg::WAVE_W-1:0]     r_wave_sel;
    logic [mwo_pkg::CFG_DATA_W-1:0] r_phase_step;
    logic [mwo_pkg::GAIN_W-1:0]     r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_sel   <= mwo_pkg::WAVE_SINE;
            r_phase_step <= '0;
            r_gain       <= mwo_pkg::GAIN_RESET;
        end else if (i_cfg_wr_en) begin
            case (mwo_pkg::t_cfg_idx'(i_cfg_index))
                mwo_pkg::CFG_WAVE_SELECT: begin
                    r_wave_sel <= i_cfg_wdata[mwo_pkg::WAVE_W-1:0];
                end
                mwo_pkg::CFG_PHASE_STEP: begin
                    r_phase_step <= i_cfg_wdata;
                end
                mwo_pkg::CFG_GAIN: begin
                    r_gain <= i_cfg_wdata[mwo_pkg::GAIN_W-1:0];
                end
                default: begin
                    // index past the register list: drop the write
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: each stage loads when it is empty or the one after it
    // moves, so bubbles close up and a stall reaches input only when all are full.
    // ---------------------------------------------------------------
    logic r_s1_v;
    logic r_s2_v;
    logic r_s3_v;
    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;
    logic w_acc;

    assign w_rdy3     = !r_s3_v || i_m_tready;
    assign w_rdy2     = !r_s2_v || w_rdy3;
    assign w_rdy1     = !r_s1_v || w_rdy2;
    assign o_s_tready = w_rdy1;
    assign w_acc      = i_s_tvalid && w_rdy1;

    // ---------------------------------------------------------------
    // Phase accumulator. The step is scaled to the accumulator width.
    // ---------------------------------------------------------------
    logic [PHASE_BITS-1:0] r_phase;
    logic                  r_wrap;
    logic [PHASE_BITS-1:0] w_step;
    logic [PHASE_BITS-1:0] w_cur;
    logic [PHASE_BITS-1:0] n_phase;
    logic                  n_wrap;
    logic                  w_restart;

    if (PHASE_BITS >= 32) begin : g_step_up
        assign w_step = PHASE_BITS'(r_phase_step) << (PHASE_BITS - 32);
    end else begin : g_step_down
        assign w_step = PHASE_BITS'(r_phase_step >> (32 - PHASE_BITS));
    end

    assign w_restart          = i_s_tdata[0];
    // restart zeroes the phase before this sample is produced
    assign w_cur              = w_restart ? '0 : r_phase;
    // carry out of the add means the phase passed a full turn
    assign {n_wrap, n_phase}  = {1'b0, w_cur} + {1'b0, w_step};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_wrap  <= 1'b1;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_wrap  <= n_wrap;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: sine ROM address with quarter-wave mirroring, registered read
    // ---------------------------------------------------------------
    logic [15:0]                w_rom [TABLE_SIZE];
    logic [1:0]                 w_quad;
    logic [TABLE_ADDR_BITS-1:0] w_idx;
    logic [TABLE_ADDR_BITS-1:0] w_addr;

    for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_rom
        assign w_rom[k] = mwo_pkg::quarter_sine(k, TABLE_ADDR_BITS);
    end

    assign w_quad = w_cur[PHASE_BITS-1 -: 2];
    assign w_idx  = w_cur[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    // odd quadrants run the table backward: entry N - idx
    assign w_addr = w_quad[0] ? ('0 - w_idx) : w_idx;

    logic [15:0] r_s1_rom;
    logic [15:0] r_s1_top16;
    logic        r_s1_unit;
    logic        r_s1_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_rdy1) begin
            r_s1_v <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_rom   <= w_rom[w_addr];
            r_s1_top16 <= w_cur[PHASE_BITS-1 -: 16];
            // mirrored index zero falls past the table end: peak value
            r_s1_unit  <= w_quad[0] && (w_idx == '0);
            r_s1_start <= w_restart || r_wrap;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: wave magnitude and sign, multiply by gain
    // ---------------------------------------------------------------
    logic [MAG_W-1:0]  w_mag;
    logic              w_neg;
    logic [PROD_W-1:0] w_prod;

    always_comb begin
        w_mag = '0;
        w_neg = 1'b0;
        case (mwo_pkg::t_wave'(r_wave_sel))
            mwo_pkg::WAVE_SINE: begin
                w_mag = r_s1_unit ? mwo_pkg::UNIT : MAG_W'(r_s1_rom);
                w_neg = r_s1_top16[15];
            end
            mwo_pkg::WAVE_SAW: begin
                // value is top16 - 1.0; take magnitude around the midpoint
                if (r_s1_top16[15]) begin
                    w_mag = MAG_W'(r_s1_top16[14:0]);
                    w_neg = 1'b0;
                end else begin
                    w_mag = mwo_pkg::UNIT - MAG_W'(r_s1_top16);
                    w_neg = 1'b1;
                end
            end
            mwo_pkg::WAVE_RECT: begin
                w_mag = mwo_pkg::UNIT;
                w_neg = !r_s1_top16[15];
            end
            default: begin
                // unused waveform code: silent sample
                w_mag = '0;
                w_neg = 1'b0;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_mag) * PROD_W'(r_gain);

    logic [PROD_W-1:0] r_s2_prod;
    logic              r_s2_neg;
    logic              r_s2_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_rdy2) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_s1_v) begin
            r_s2_prod  <= w_prod;
            r_s2_neg   <= w_neg;
            r_s2_start <= r_s1_start;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: times full scale (shift and subtract), drop 30 fraction
    // bits, saturate, apply sign. This register is the output register.
    // ---------------------------------------------------------------
    logic [SCL_W-1:0]       w_scaled;
    logic [V_W-1:0]         w_v;
    logic [V_W-1:0]         w_sat;
    logic [V_W-1:0]         w_neg_v;
    logic [SAMPLE_BITS-1:0] w_sample;

    assign w_scaled = (SCL_W'(r_s2_prod) << (SAMPLE_BITS - 1)) - SCL_W'(r_s2_prod);
    assign w_v      = w_scaled[SCL_W-1:30];

    always_comb begin
        if (r_s2_neg) begin
            w_sat = (w_v > NEG_LIM) ? NEG_LIM : w_v;
        end else begin
            w_sat = (w_v > FULL_V) ? FULL_V : w_v;
        end
    end

    assign w_neg_v  = '0 - w_sat;
    assign w_sample = r_s2_neg ? w_neg_v[SAMPLE_BITS-1:0] : w_sat[SAMPLE_BITS-1:0];

    logic [SAMPLE_BITS-1:0] r_s3_sample;
    logic                   r_s3_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_rdy3) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_s2_v) begin
            r_s3_sample <= w_sample;
            r_s3_start  <= r_s2_start;
        end
    end

    assign o_m_tvalid = r_s3_v;
    assign o_m_tdata  = OUT_W'(r_s3_sample);
    assign o_m_tuser  = r_s3_start;

endmodule

>>> rtl/mwo_checker.sv
`timescale 1ns / 1ps
`include "multi_waveform_oscillator_defines.svh"

module mwo_checker #(
    parameter int OUT_W = 16
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata,
    input logic             o_m_tuser
);

    logic       w_in;
    logic       w_out;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;

    assign w_in  = i_s_tvalid && o_s_tready;
    assign w_out = o_m_tvalid && i_m_tready;
    assign n_cnt = r_cnt + 3'(w_in) - 3'(w_out);

    // transactions accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `MWO_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready), (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)), "stalled output changed")
    `MWO_ASSERT_IMP(a_no_invented, i_clk, i_rst_n, o_m_tvalid, (r_cnt != 3'd0), "output without a pending input")
    `MWO_ASSERT_IMP(a_ready_when_room, i_clk, i_rst_n, (r_cnt < 3'(mwo_pkg::PIPE_DEPTH)), o_s_tready, "input refused with pipeline room")
    `MWO_ASSERT_IMP(a_full_blocks, i_clk, i_rst_n, ((r_cnt == 3'(mwo_pkg::PIPE_DEPTH)) && !w_out), !o_s_tready, "input taken with pipeline full")

endmodule

bind multi_waveform_oscillator mwo_checker #(
    .OUT_W(OUT_W)
) u_mwo_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

>>> dv/multi_waveform_oscillator_test.sv
`timescale 1ns / 1ps

module multi_waveform_oscillator_test;

    localparam int SAMPLE_W  = mwo_pkg::SAMPLE_BITS_DEF;
    localparam int OUT_W     = ((SAMPLE_W + 7) / 8) * 8;
    localparam int TABLE_N   = 1 << mwo_pkg::TABLE_ADDR_BITS_DEF;
    localparam int ONE_Q15   = 32768;
    localparam int FULL_LVL  = (1 << (SAMPLE_W - 1)) - 1;

    // Unused waveform code: the block must emit silence for it
    localparam logic [mwo_pkg::WAVE_W-1:0] WAVE_SILENT = 2'd3;

    // Cycles without any transaction before the run is declared hung
    localparam int IDLE_LIMIT   = 4000;
    // Long receiver hold-off that backs the pipeline up into the input
    localparam int HOLD_CYCLES  = 300;
    // Quiet cycles after the last sample, to catch stray output transactions
    localparam int DRAIN_CYCLES = mwo_pkg::PIPE_DEPTH + 5;

    localparam int SEGMENTS     = 26;
    localparam int SEGMENT_LEN  = 50;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pcm;
        logic                period_start;
    } t_sample;

    // DUT ports
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_wr_en = 1'b0;
    logic [mwo_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [mwo_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [mwo_pkg::IN_DATA_W-1:0]  i_s_tdata   = '0;   // [0] restart, rest zero
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b0;
    logic [OUT_W-1:0]               o_m_tdata;          // [SAMPLE_W-1:0] pcm_sample
    logic                           o_m_tuser;          // [0] period_start

    // Stimulus and scoreboard storage
    bit      pending_restarts[$];
    t_sample expected_samples[$];
    int      err_count = 0;

    // Oscillator mirror: phase, wrap flag, register copies and the sine table
    logic [31:0]                 osc_phase = '0;
    logic                        osc_wrap  = 1'b1;
    logic [mwo_pkg::WAVE_W-1:0]  cfg_wave  = mwo_pkg::WAVE_SINE;
    logic [31:0]                 cfg_step  = '0;
    logic [mwo_pkg::GAIN_W-1:0]  cfg_gain  = mwo_pkg::GAIN_RESET;
    logic [15:0]                 sine_rom [0:TABLE_N-1];

    // Idling knobs, in percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Hold-off handshake: the stimulus bumps the request count, the receiver serves it
    int hold_req  = 0;
    int hold_ack  = 0;
    int hold_left = 0;

    logic in_fire   = 1'b0;
    int   idle_cycles = 0;

    multi_waveform_oscillator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Quarter-wave sine entry in Q15: Q30 Taylor series to x^11 by Horner,
    // truncating every product and division, then rounded to 15 bits.
    function automatic logic [15:0] sine_entry(input int unsigned k);
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] poly;
        logic [63:0] val;
        ang    = (64'(k) * mwo_pkg::HALF_PI_Q30) >> mwo_pkg::TABLE_ADDR_BITS_DEF;
        ang_sq = (ang * ang) >> 30;
        poly   = mwo_pkg::Q30_ONE - ang_sq / 64'd110;
        poly   = mwo_pkg::Q30_ONE - ((ang_sq * poly) >> 30) / 64'd72;
        poly   = mwo_pkg::Q30_ONE - ((ang_sq * poly) >> 30) / 64'd42;
        poly   = mwo_pkg::Q30_ONE - ((ang_sq * poly) >> 30) / 64'd20;
        poly   = mwo_pkg::Q30_ONE - ((ang_sq * poly) >> 30) / 64'd6;
        val    = (((ang * poly) >> 30) + 64'd16384) >> 15;
        if (val > 64'(ONE_Q15)) begin
            val = 64'(ONE_Q15);
        end
        return val[15:0];
    endfunction

    initial begin
        for (int k = 0; k < TABLE_N; k++) begin
            sine_rom[k] = sine_entry(k);
        end
    end

    // Waveform level at a phase, 2^15 standing for full scale
    function automatic int wave_level(input logic [31:0] phase);
        logic [15:0] top;
        logic [1:0]  quad;
        logic [mwo_pkg::TABLE_ADDR_BITS_DEF-1:0] idx;
        int          mag;
        top  = phase[31:16];
        quad = top[15:14];
        idx  = phase[29 -: mwo_pkg::TABLE_ADDR_BITS_DEF];
        case (cfg_wave)
            mwo_pkg::WAVE_SINE: begin
                // odd quadrants read the table mirrored; index zero there is the peak
                if (quad[0]) begin
                    mag = (idx == 0) ? ONE_Q15 : int'(sine_rom[TABLE_N - int'(idx)]);
                end else begin
                    mag = int'(sine_rom[idx]);
                end
                return quad[1] ? -mag : mag;
            end
            mwo_pkg::WAVE_SAW:  return int'(top) - ONE_Q15;
            mwo_pkg::WAVE_RECT: return (quad < 2'd2) ? -ONE_Q15 : ONE_Q15;
            default:            return 0;
        endcase
    endfunction

    // Apply gain and full scale, truncate toward zero, saturate
    function automatic logic [SAMPLE_W-1:0] scale_level(input int level);
        logic [63:0] mag;
        logic [63:0] v;
        mag = (level < 0) ? 64'(-level) : 64'(level);
        v   = (mag * 64'(cfg_gain) * 64'(FULL_LVL)) >> 30;
        if (level < 0) begin
            if (v > 64'(FULL_LVL + 1)) begin
                v = 64'(FULL_LVL + 1);
            end
            v = 64'd0 - v;
        end else if (v > 64'(FULL_LVL)) begin
            v = 64'(FULL_LVL);
        end
        return v[SAMPLE_W-1:0];
    endfunction

    // Produce the sample for one input transaction and advance the phase
    function automatic t_sample next_sample(input logic restart);
        t_sample     s;
        logic [31:0] prev;
        if (restart) begin
            osc_phase = '0;
            osc_wrap  = 1'b1;
        end
        s.pcm          = scale_level(wave_level(osc_phase));
        s.period_start = osc_wrap;
        prev      = osc_phase;
        osc_phase = osc_phase + cfg_step;
        osc_wrap  = (osc_phase < prev);
        return s;
    endfunction

    // Check output transactions against the oldest expectation, then
    // predict from the input transaction taken at this same edge.
    always @(posedge i_clk) begin
        t_sample want;
        in_fire <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected output transaction: pcm_sample %0d period_start %0b",
                       $signed(o_m_tdata[SAMPLE_W-1:0]), o_m_tuser);
                err_count++;
            end else begin
                want = expected_samples.pop_front();
                if (o_m_tdata[SAMPLE_W-1:0] !== want.pcm) begin
                    $error("pcm_sample: expected %0d, actual %0d",
                           $signed(want.pcm), $signed(o_m_tdata[SAMPLE_W-1:0]));
                    err_count++;
                end
                if (o_m_tuser !== want.period_start) begin
                    $error("period_start: expected %0b, actual %0b",
                           want.period_start, o_m_tuser);
                    err_count++;
                end
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            expected_samples.push_back(next_sample(i_s_tdata[0]));
        end
    end

    // Input driver: hold an offered transaction until it is taken, then
    // offer the next pending one or go idle at random.
    always @(negedge i_clk) begin
        if (!i_s_tvalid || in_fire) begin
            if (pending_restarts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= mwo_pkg::IN_DATA_W'(pending_restarts.pop_front());
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Output receiver: random stalls, plus a counted hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (hold_ack != hold_req) begin
            hold_ack   <= hold_req;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Wait until every pending transaction went in and every sample came out.
    // Look just after the edge so the scoreboard has settled.
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #0.5;
        end while (pending_restarts.size() != 0 || i_s_tvalid ||
                   expected_samples.size() != 0);
    endtask

    task automatic write_reg(input mwo_pkg::t_cfg_idx idx,
                             input logic [mwo_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        case (idx)
            mwo_pkg::CFG_WAVE_SELECT: cfg_wave = value[mwo_pkg::WAVE_W-1:0];
            mwo_pkg::CFG_PHASE_STEP:  cfg_step = value;
            mwo_pkg::CFG_GAIN:        cfg_gain = value[mwo_pkg::GAIN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Drain the block, then load all three registers
    task automatic apply_setting(input logic [mwo_pkg::WAVE_W-1:0] wave,
                                 input logic [31:0] step,
                                 input logic [mwo_pkg::GAIN_W-1:0] gain);
        wait_drained();
        write_reg(mwo_pkg::CFG_WAVE_SELECT, mwo_pkg::CFG_DATA_W'(wave));
        write_reg(mwo_pkg::CFG_PHASE_STEP, step);
        write_reg(mwo_pkg::CFG_GAIN, mwo_pkg::CFG_DATA_W'(gain));
    endtask

    task automatic queue_restarts(input bit pattern[]);
        foreach (pattern[i]) begin
            pending_restarts.push_back(pattern[i]);
        end
    endtask

    initial begin
        logic [mwo_pkg::WAVE_W-1:0] wave;
        logic [31:0]                step;
        logic [mwo_pkg::GAIN_W-1:0] gain;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: sine at zero step gives silence, first sample starts a period
        queue_restarts('{1'b0, 1'b1});

        // Quarter-turn steps walk every quadrant; odd quadrants hit the mirrored peak
        apply_setting(mwo_pkg::WAVE_SINE, 32'h4000_0000, 16'h8000);
        queue_restarts('{1'b0, 1'b0, 1'b0, 1'b0, 1'b0});

        // Saw at maximum gain, through a wrap
        apply_setting(mwo_pkg::WAVE_SAW, 32'h4000_0000, 16'hFFFF);
        queue_restarts('{1'b0, 1'b0, 1'b0, 1'b0});

        // Overdriven rectangle clips at both rails
        apply_setting(mwo_pkg::WAVE_RECT, 32'h8000_0000, 16'hFFFF);
        queue_restarts('{1'b1, 1'b0, 1'b0});

        // Unused waveform code, zero gain, largest step
        apply_setting(WAVE_SILENT, 32'hFFFF_FFFF, 16'h0000);
        queue_restarts('{1'b1, 1'b0, 1'b0});

        // One table entry per sample, restart mid-stream
        apply_setting(mwo_pkg::WAVE_SINE, 32'h0010_0000, 16'h8000);
        queue_restarts('{1'b1, 1'b0, 1'b0, 1'b1});

        // Smallest nonzero step
        apply_setting(mwo_pkg::WAVE_RECT, 32'h0000_0001, 16'h8000);
        queue_restarts('{1'b0, 1'b1});

        // Random segments, cycling through the idling modes
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wave = ($urandom_range(9) == 0) ? WAVE_SILENT
                                            : mwo_pkg::WAVE_W'($urandom_range(2));
            case ($urandom_range(5))
                0:       step = 32'h0000_0000;
                1:       step = 32'hFFFF_FFFF;
                2:       step = $urandom_range(32'h0010_0000);
                3:       step = 32'h8000_0000 + $urandom_range(255) - 128;
                default: step = $urandom;
            endcase
            case ($urandom_range(5))
                0:       gain = 16'h0000;
                1:       gain = 16'hFFFF;
                2:       gain = mwo_pkg::GAIN_RESET;
                default: gain = mwo_pkg::GAIN_W'($urandom_range(16'hFFFF));
            endcase
            apply_setting(wave, step, gain);

            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            // Back the pipeline up while the sender keeps offering
            if (seg == 8) begin
                hold_req++;
            end

            for (int n = 0; n < SEGMENT_LEN; n++) begin
                pending_restarts.push_back($urandom_range(15) == 0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        #0.5;
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
